/* src/nrpe_pkg.sv */
// shared types, codes and character helpers of the rmc position extractor
`default_nettype none
package nrpe_pkg;

  typedef enum logic [2:0] {
    STAT_VALID     = 3'd0,
    STAT_VOID      = 3'd1,
    STAT_NO_DOLLAR = 3'd2,
    STAT_NO_STAR   = 3'd3,
    STAT_BAD_SUM   = 3'd4,
    STAT_NOT_GNRMC = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_LAT    = 2'd1,
    KIND_LON    = 2'd2
  } kind_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_VOID   = 8'h56;

  localparam logic [2:0] TOK_ID  = 3'd1;
  localparam logic [2:0] TOK_LAT = 3'd4;
  localparam logic [2:0] TOK_LON = 3'd6;
  localparam logic [2:0] TOK_MAX = 3'd7;

  localparam logic [3:0] ID_LEN  = 4'd6;
  localparam logic [3:0] ID_FAIL = 4'd15;

  // expected header characters in order
  function automatic logic [7:0] id_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h47;
      4'd2:    c = 8'h4E;
      4'd3:    c = 8'h52;
      4'd4:    c = 8'h4D;
      4'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // bit 4 set when the byte is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/nrpe_text_ram.sv */
// single-port-write, registered-read buffer for latitude and longitude text
`default_nettype none
module nrpe_text_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/nrpe_scan.sv */
// per-byte sentence scanner: checksum, hex, token tracking and text writes
`default_nettype none
module nrpe_scan #(
  parameter int TEXT_CHARS = 16,
  parameter int LW         = 5,
  parameter int AW         = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  acc,
  input  wire logic [7:0]            line_byte,
  input  wire logic                  line_end,
  output nrpe_pkg::status_t          status_o,
  output logic      [LW-1:0]         lat_len_o,
  output logic      [LW-1:0]         lon_len_o,
  output logic                       wr_en_o,
  output logic      [AW-1:0]         wr_addr_o,
  output logic      [7:0]            wr_data_o
);
  import nrpe_pkg::*;

  localparam logic [LW-1:0] TC_L = LW'(TEXT_CHARS);
  localparam logic [AW-1:0] TC_A = AW'(TEXT_CHARS);

  logic          bz_r, bz_nxt, bz_u;
  logic          dollar_r, dollar_nxt, dollar_u;
  logic          void_r, void_nxt, void_u;
  logic [7:0]    xor_r, xor_nxt, xor_u;
  logic [7:0]    xstar_r, xstar_nxt, xstar_u;
  logic          star_r, star_nxt, star_u;
  logic [7:0]    hex_r, hex_nxt, hex_u;
  logic          hovf_r, hovf_nxt, hovf_u;
  logic          hstop_r, hstop_nxt, hstop_u;
  logic [2:0]    tcnt_r, tcnt_nxt, tcnt_u;
  logic          tin_r, tin_nxt, tin_u;
  logic [3:0]    id_r, id_nxt, id_u;
  logic [3:0]    id_snap_r, id_snap_nxt, id_snap_u;
  logic [LW-1:0] lat_r, lat_nxt, lat_u;
  logic [LW-1:0] lon_r, lon_nxt, lon_u;
  logic [LW-1:0] lat_snap_r, lat_snap_nxt, lat_snap_u;
  logic [LW-1:0] lon_snap_r, lon_snap_nxt, lon_snap_u;
  logic [4:0]    hd;
  logic [2:0]    cnt;

  always_comb begin
    bz_u       = bz_r;
    dollar_u   = dollar_r;
    void_u     = void_r;
    xor_u      = xor_r;
    xstar_u    = xstar_r;
    star_u     = star_r;
    hex_u      = hex_r;
    hovf_u     = hovf_r;
    hstop_u    = hstop_r;
    tcnt_u     = tcnt_r;
    tin_u      = tin_r;
    id_u       = id_r;
    id_snap_u  = id_snap_r;
    lat_u      = lat_r;
    lon_u      = lon_r;
    lat_snap_u = lat_snap_r;
    lon_snap_u = lon_snap_r;
    wr_en_o    = 1'b0;
    wr_addr_o  = AW'(lat_r);
    wr_data_o  = line_byte;
    hd         = hex_digit(line_byte);
    cnt        = tcnt_r;

    if (line_byte == CH_VOID) begin
      void_u = 1'b1;
    end

    // checksum field after the star
    if (line_byte == CH_STAR) begin
      xstar_u    = xor_r;
      id_snap_u  = id_r;
      lat_snap_u = lat_r;
      lon_snap_u = lon_r;
      star_u     = 1'b1;
      hex_u      = 8'd0;
      hovf_u     = 1'b0;
      hstop_u    = 1'b0;
    end else if (star_r && !hstop_r) begin
      if (!hd[4]) begin
        hstop_u = 1'b1;
      end else begin
        if (hex_r[7:4] != 4'd0) begin
          hovf_u = 1'b1;
        end
        hex_u = {hex_r[3:0], hd[3:0]};
      end
    end

    if (bz_r) begin
      dollar_u = (line_byte == CH_DOLLAR);
      bz_u     = 1'b0;
    end else begin
      xor_u = xor_r ^ line_byte;
    end

    // token tracking
    if (line_byte == CH_COMMA) begin
      tin_u = 1'b0;
    end else begin
      if (!tin_r) begin
        if (cnt != TOK_MAX) begin
          cnt = cnt + 3'd1;
        end
        tin_u  = 1'b1;
        tcnt_u = cnt;
      end
      if (cnt == TOK_ID) begin
        if (id_r != ID_FAIL) begin
          if (id_r < ID_LEN && line_byte == id_char(id_r)) begin
            id_u = id_r + 4'd1;
          end else begin
            id_u = ID_FAIL;
          end
        end
      end else if (cnt == TOK_LAT) begin
        if (lat_r < TC_L) begin
          wr_en_o   = 1'b1;
          wr_addr_o = AW'(lat_r);
          lat_u     = lat_r + LW'(1);
        end
      end else if (cnt == TOK_LON) begin
        if (lon_r < TC_L) begin
          wr_en_o   = 1'b1;
          wr_addr_o = TC_A + AW'(lon_r);
          lon_u     = lon_r + LW'(1);
        end
      end
    end
    wr_en_o = wr_en_o & acc;

    if (void_u) begin
      status_o = STAT_VOID;
    end else if (!dollar_u) begin
      status_o = STAT_NO_DOLLAR;
    end else if (!star_u) begin
      status_o = STAT_NO_STAR;
    end else if (hovf_u || hex_u != xstar_u) begin
      status_o = STAT_BAD_SUM;
    end else if (id_snap_u != ID_LEN) begin
      status_o = STAT_NOT_GNRMC;
    end else begin
      status_o = STAT_VALID;
    end
    lat_len_o = lat_snap_u;
    lon_len_o = lon_snap_u;
  end

  always_comb begin
    bz_nxt       = bz_r;
    dollar_nxt   = dollar_r;
    void_nxt     = void_r;
    xor_nxt      = xor_r;
    xstar_nxt    = xstar_r;
    star_nxt     = star_r;
    hex_nxt      = hex_r;
    hovf_nxt     = hovf_r;
    hstop_nxt    = hstop_r;
    tcnt_nxt     = tcnt_r;
    tin_nxt      = tin_r;
    id_nxt       = id_r;
    id_snap_nxt  = id_snap_r;
    lat_nxt      = lat_r;
    lon_nxt      = lon_r;
    lat_snap_nxt = lat_snap_r;
    lon_snap_nxt = lon_snap_r;
    if (acc) begin
      if (line_end) begin
        bz_nxt       = 1'b1;
        dollar_nxt   = 1'b0;
        void_nxt     = 1'b0;
        xor_nxt      = 8'd0;
        xstar_nxt    = 8'd0;
        star_nxt     = 1'b0;
        hex_nxt      = 8'd0;
        hovf_nxt     = 1'b0;
        hstop_nxt    = 1'b0;
        tcnt_nxt     = 3'd0;
        tin_nxt      = 1'b0;
        id_nxt       = 4'd0;
        id_snap_nxt  = 4'd0;
        lat_nxt      = '0;
        lon_nxt      = '0;
        lat_snap_nxt = '0;
        lon_snap_nxt = '0;
      end else begin
        bz_nxt       = bz_u;
        dollar_nxt   = dollar_u;
        void_nxt     = void_u;
        xor_nxt      = xor_u;
        xstar_nxt    = xstar_u;
        star_nxt     = star_u;
        hex_nxt      = hex_u;
        hovf_nxt     = hovf_u;
        hstop_nxt    = hstop_u;
        tcnt_nxt     = tcnt_u;
        tin_nxt      = tin_u;
        id_nxt       = id_u;
        id_snap_nxt  = id_snap_u;
        lat_nxt      = lat_u;
        lon_nxt      = lon_u;
        lat_snap_nxt = lat_snap_u;
        lon_snap_nxt = lon_snap_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bz_r       <= 1'b1;
      dollar_r   <= 1'b0;
      void_r     <= 1'b0;
      xor_r      <= 8'd0;
      xstar_r    <= 8'd0;
      star_r     <= 1'b0;
      hex_r      <= 8'd0;
      hovf_r     <= 1'b0;
      hstop_r    <= 1'b0;
      tcnt_r     <= 3'd0;
      tin_r      <= 1'b0;
      id_r       <= 4'd0;
      id_snap_r  <= 4'd0;
      lat_r      <= '0;
      lon_r      <= '0;
      lat_snap_r <= '0;
      lon_snap_r <= '0;
    end else begin
      bz_r       <= bz_nxt;
      dollar_r   <= dollar_nxt;
      void_r     <= void_nxt;
      xor_r      <= xor_nxt;
      xstar_r    <= xstar_nxt;
      star_r     <= star_nxt;
      hex_r      <= hex_nxt;
      hovf_r     <= hovf_nxt;
      hstop_r    <= hstop_nxt;
      tcnt_r     <= tcnt_nxt;
      tin_r      <= tin_nxt;
      id_r       <= id_nxt;
      id_snap_r  <= id_snap_nxt;
      lat_r      <= lat_nxt;
      lon_r      <= lon_nxt;
      lat_snap_r <= lat_snap_nxt;
      lon_snap_r <= lon_snap_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/nmea_rmc_position_extractor.sv */
// top level: rmc sentence scanner, text buffer and result sequencer
// Takes one sentence byte per cycle on the input stream while idle. On the
// byte marked tlast it stops accepting input and sends one status
// transaction, then, for a valid sentence, the latitude and longitude text
// (fourth and sixth non-empty tokens before the last '*') one character per
// transaction, read from a 2*TEXT_CHARS byte buffer with a registered read.
// The burst takes 1 + lat length + lon length transactions, one per cycle
// after the first buffer read when the output is not stalled; input resumes
// after the last one is loaded into the output register. Text beyond
// TEXT_CHARS characters is dropped.
`default_nettype none
module nmea_rmc_position_extractor #(
  parameter int TEXT_CHARS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // line_byte
  input  wire logic        in_tlast,   // line_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // status [2:0], text_char [10:3], zero
  output logic      [1:0]  out_tuser,  // item_kind
  output logic             out_tlast   // last
);
  import nrpe_pkg::*;

  localparam int LW = $clog2(TEXT_CHARS + 1);
  localparam int AW = $clog2(2 * TEXT_CHARS);
  localparam logic [AW-1:0] TC_A = AW'(TEXT_CHARS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STAT = 3'b010,
    S_TEXT = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  status_t       st_r, st_nxt, scan_st;
  logic [LW-1:0] lat_len_r, lat_len_nxt, lon_len_r, lon_len_nxt;
  logic [LW-1:0] scan_lat, scan_lon;
  logic [LW-1:0] idx_r, idx_nxt, cur_len, idx_inc;
  logic          sel_r, sel_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  kind_t         pend_kind_r, pend_kind_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  status_t       out_st_r, out_st_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;
  logic          acc, slot_free, consume, can_issue, tok_end, stat_last;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  nrpe_scan #(
    .TEXT_CHARS(TEXT_CHARS),
    .LW        (LW),
    .AW        (AW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .line_byte(in_tdata),
    .line_end (in_tlast),
    .status_o (scan_st),
    .lat_len_o(scan_lat),
    .lon_len_o(scan_lon),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data)
  );

  nrpe_text_ram #(
    .DEPTH(2 * TEXT_CHARS),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    slot_free = !out_valid_r || out_tready;
    consume   = (state_r == S_TEXT) && rd_pend_r && slot_free;
    can_issue = (state_r == S_TEXT) && !iss_done_r && (!rd_pend_r || consume);
    cur_len   = sel_r ? lon_len_r : lat_len_r;
    idx_inc   = idx_r + LW'(1);
    tok_end   = (idx_inc == cur_len);
    stat_last = (st_r != STAT_VALID) || (lat_len_r == '0 && lon_len_r == '0);
    rd_en     = can_issue;
    rd_addr   = sel_r ? (TC_A + AW'(idx_r)) : AW'(idx_r);

    state_nxt     = state_r;
    st_nxt        = st_r;
    lat_len_nxt   = lat_len_r;
    lon_len_nxt   = lon_len_r;
    idx_nxt       = idx_r;
    sel_nxt       = sel_r;
    iss_done_nxt  = iss_done_r;
    rd_pend_nxt   = rd_pend_r;
    pend_kind_nxt = pend_kind_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_st_nxt    = out_st_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (acc && in_tlast) begin
          st_nxt      = scan_st;
          lat_len_nxt = scan_lat;
          lon_len_nxt = scan_lon;
          state_nxt   = S_STAT;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_STATUS;
          out_st_nxt    = st_r;
          out_char_nxt  = 8'd0;
          out_last_nxt  = stat_last;
          idx_nxt       = '0;
          sel_nxt       = (lat_len_r == '0);
          iss_done_nxt  = 1'b0;
          rd_pend_nxt   = 1'b0;
          state_nxt     = stat_last ? S_IDLE : S_TEXT;
        end
      end
      S_TEXT: begin
        if (consume) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_st_nxt    = STAT_VALID;
          out_char_nxt  = rd_data;
          out_last_nxt  = pend_last_r;
          rd_pend_nxt   = 1'b0;
          if (pend_last_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (can_issue) begin
          rd_pend_nxt   = 1'b1;
          pend_kind_nxt = sel_r ? KIND_LON : KIND_LAT;
          pend_last_nxt = tok_end && (sel_r || lon_len_r == '0);
          if (tok_end) begin
            idx_nxt = '0;
            if (sel_r || lon_len_r == '0) begin
              iss_done_nxt = 1'b1;
            end else begin
              sel_nxt = 1'b1;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      iss_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      iss_done_r  <= iss_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r        <= st_nxt;
    lat_len_r   <= lat_len_nxt;
    lon_len_r   <= lon_len_nxt;
    idx_r       <= idx_nxt;
    sel_r       <= sel_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_last_r <= pend_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_st_r    <= out_st_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_char_r, out_st_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* sim/nrpe_result_monitor.sv */
// result monitor: predicts every result of the rmc position extractor and compares
`timescale 1ns / 1ps
module nrpe_result_monitor #(
  parameter int TEXT_CHARS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending
);
  import nrpe_pkg::*;

  typedef struct {
    kind_t      kind;
    status_t    status;
    logic [7:0] ch;
    logic       last;
  } rmc_result_t;

  localparam logic [7:0] RMC_ID [6] = '{CH_DOLLAR, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};

  rmc_result_t sentence_items [$];
  rmc_result_t head_item;

  logic       first_byte;
  logic       dollar_ok;
  logic       void_seen;
  logic       star_seen;
  logic [7:0] xor_run;
  logic [7:0] xor_at_star;
  logic [7:0] hex_val;
  logic       hex_ovf;
  logic       hex_stop;
  logic [2:0] tok_count;
  logic       in_token;
  logic [3:0] id_pos;
  logic [3:0] id_at_star;
  int         lat_len;
  int         lon_len;
  int         lat_at_star;
  int         lon_at_star;
  logic [7:0] lat_text [TEXT_CHARS];
  logic [7:0] lon_text [TEXT_CHARS];

  function automatic int nibble_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    return -1;
  endfunction

  task automatic start_new_sentence();
    first_byte  = 1'b1;
    dollar_ok   = 1'b0;
    void_seen   = 1'b0;
    star_seen   = 1'b0;
    xor_run     = '0;
    xor_at_star = '0;
    hex_val     = '0;
    hex_ovf     = 1'b0;
    hex_stop    = 1'b0;
    tok_count   = '0;
    in_token    = 1'b0;
    id_pos      = '0;
    id_at_star  = '0;
    lat_len     = 0;
    lon_len     = 0;
    lat_at_star = 0;
    lon_at_star = 0;
  endtask

  task automatic parse_sentence_byte(input logic [7:0] b, input logic fin);
    int          d;
    int          v;
    int          n_lat;
    int          n_lon;
    status_t     st;
    rmc_result_t r;
    if (b == CH_VOID) void_seen = 1'b1;

    // the last star fixes the checksum and the token view
    if (b == CH_STAR) begin
      xor_at_star = xor_run;
      id_at_star  = id_pos;
      lat_at_star = lat_len;
      lon_at_star = lon_len;
      star_seen   = 1'b1;
      hex_val     = '0;
      hex_ovf     = 1'b0;
      hex_stop    = 1'b0;
    end else if (star_seen && !hex_stop) begin
      d = nibble_value(b);
      if (d < 0) begin
        hex_stop = 1'b1;
      end else begin
        v = (int'(hex_val) << 4) | d;
        if (v > 255) hex_ovf = 1'b1;
        hex_val = v[7:0];
      end
    end

    if (first_byte) begin
      dollar_ok  = (b == CH_DOLLAR);
      first_byte = 1'b0;
    end else begin
      xor_run ^= b;
    end

    // only non-empty tokens are counted
    if (b == CH_COMMA) begin
      in_token = 1'b0;
    end else begin
      if (!in_token) begin
        if (tok_count < TOK_MAX) tok_count++;
        in_token = 1'b1;
      end
      if (tok_count == TOK_ID) begin
        if (id_pos != ID_FAIL) begin
          if (id_pos < ID_LEN) begin
            if (b == RMC_ID[id_pos]) id_pos++;
            else id_pos = ID_FAIL;
          end else begin
            id_pos = ID_FAIL;
          end
        end
      end else if (tok_count == TOK_LAT) begin
        if (lat_len < TEXT_CHARS) begin
          lat_text[lat_len] = b;
          lat_len++;
        end
      end else if (tok_count == TOK_LON) begin
        if (lon_len < TEXT_CHARS) begin
          lon_text[lon_len] = b;
          lon_len++;
        end
      end
    end

    if (fin) begin
      if (void_seen) st = STAT_VOID;
      else if (!dollar_ok) st = STAT_NO_DOLLAR;
      else if (!star_seen) st = STAT_NO_STAR;
      else if (hex_ovf || hex_val != xor_at_star) st = STAT_BAD_SUM;
      else if (id_at_star != ID_LEN) st = STAT_NOT_GNRMC;
      else st = STAT_VALID;
      n_lat = (st == STAT_VALID) ? lat_at_star : 0;
      n_lon = (st == STAT_VALID) ? lon_at_star : 0;

      r.kind   = KIND_STATUS;
      r.status = st;
      r.ch     = '0;
      r.last   = (n_lat + n_lon == 0);
      sentence_items.push_back(r);
      for (int i = 0; i < n_lat; i++) begin
        r.kind   = KIND_LAT;
        r.status = STAT_VALID;
        r.ch     = lat_text[i];
        r.last   = (i == n_lat - 1) && (n_lon == 0);
        sentence_items.push_back(r);
      end
      for (int i = 0; i < n_lon; i++) begin
        r.kind   = KIND_LON;
        r.status = STAT_VALID;
        r.ch     = lon_text[i];
        r.last   = (i == n_lon - 1);
        sentence_items.push_back(r);
      end
      start_new_sentence();
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_new_sentence();
      sentence_items.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) parse_sentence_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (sentence_items.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got kind %0d data %h last %0d",
                   $time, out_tuser, out_tdata, out_tlast);
          fail_count++;
        end else begin
          head_item = sentence_items.pop_front();
          compare_field("kind", int'(head_item.kind), int'(out_tuser));
          compare_field("status", int'(head_item.status), int'(out_tdata[2:0]));
          compare_field("text_char", int'(head_item.ch), int'(out_tdata[10:3]));
          compare_field("tdata padding", 0, int'(out_tdata[15:11]));
          compare_field("last", int'(head_item.last), int'(out_tlast));
        end
      end
    end
    pending = sentence_items.size();
  end

endmodule

/* sim/tb_nmea_rmc_position_extractor.sv */
// testbench top: sentence stimulus, reset, watchdog and verdict for the rmc position extractor
`timescale 1ns / 1ps
module tb_nmea_rmc_position_extractor;
  import nrpe_pkg::*;

  localparam int TEXT_CHARS     = 16;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_BYTES   = 90;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          bytes_sent;
  logic [7:0]  line_q [$];
  string       field_set = "0123456789.NSEWA";

  always #(CLK_PERIOD / 2) clk = ~clk;

  nmea_rmc_position_extractor #(
    .TEXT_CHARS(TEXT_CHARS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  nrpe_result_monitor #(
    .TEXT_CHARS(TEXT_CHARS)
  ) u_monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] line_sum();
    logic [7:0] x;
    x = '0;
    for (int i = 1; i < line_q.size(); i++) x ^= line_q[i];
    return x;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_hex(input logic [7:0] v, input bit lower);
    line_q.push_back(hex_char(v[7:4], lower));
    line_q.push_back(hex_char(v[3:0], lower));
  endfunction

  // star plus checksum of everything after the first byte, optionally corrupted
  function automatic void add_star_sum(input logic [7:0] flip, input bit lower);
    logic [7:0] s;
    s = line_sum();
    line_q.push_back(CH_STAR);
    add_hex(s ^ flip, lower);
  endfunction

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return field_set[$urandom_range(0, field_set.len() - 1)];
    if (r < 95) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic gen_random_line();
    int         len;
    logic [7:0] s;
    line_q.delete();
    if ($urandom_range(0, 99) < 10) begin
      len = $urandom_range(1, 12);
      repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 19) != 0) line_q.push_back(CH_DOLLAR);
      case ($urandom_range(0, 19))
        0:       add_text("GPRMC");
        1:       add_text("GNRM");
        2:       add_text("GNRMCA");
        3:       add_text(",GNRMC");
        4:       add_text("gnrmc");
        default: add_text("GNRMC");
      endcase
      repeat ($urandom_range(3, 9)) begin
        line_q.push_back(CH_COMMA);
        if ($urandom_range(0, 5) == 0) line_q.push_back(CH_COMMA);
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(TEXT_CHARS - 2, TEXT_CHARS + 4)
                                           : $urandom_range(0, 5);
        repeat (len) line_q.push_back(field_char());
        if ($urandom_range(0, 29) == 0) line_q.push_back(CH_STAR);
      end
      if ($urandom_range(0, 99) >= 5) begin
        s = line_sum();
        line_q.push_back(CH_STAR);
        if ($urandom_range(0, 9) == 0) s ^= 8'($urandom_range(1, 255));
        case ($urandom_range(0, 19))
          0: ;
          1: line_q.push_back(hex_char(s[3:0], 1'($urandom_range(0, 1))));
          2: begin
            line_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
            add_hex(s, 1'b0);
          end
          3: begin
            add_text("0x");
            add_hex(s, 1'b1);
          end
          default: add_hex(s, 1'($urandom_range(0, 1)));
        endcase
        if ($urandom_range(0, 3) == 0) begin
          line_q.push_back(8'h0D);
          line_q.push_back(8'h0A);
        end else if ($urandom_range(0, 19) == 0) begin
          line_q.push_back(CH_VOID);
        end
      end
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= line_q[i];
      in_tlast  <= (i == line_q.size() - 1);
      do @(posedge clk); while (!in_tready);
      @(negedge clk);
      bytes_sent++;
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    logic [7:0] s;
    int         base;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 55;
    bytes_sent  = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // good sentence, upper and lower case checksum, cr lf after the second
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); add_star_sum(8'h00, 1'b0);
    send_line();
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); add_star_sum(8'h00, 1'b1);
    add_text("\r\n"); send_line();
    // each failing status
    line_q.delete(); add_text("$GNRMC,1,V,48,N,11,E"); add_star_sum(8'h00, 1'b0);
    send_line();
    line_q.delete(); add_text("GNRMC,1,A,48,N,11,E"); add_star_sum(8'h00, 1'b0);
    send_line();
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); send_line();
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); add_star_sum(8'h01, 1'b0);
    send_line();
    line_q.delete(); add_text("$GPRMC,1,A,48,N,11,E"); add_star_sum(8'h00, 1'b0);
    send_line();
    line_q.delete(); add_text("$,GNRMC,1"); add_star_sum(8'h00, 1'b0); send_line();
    // empty tokens, extreme bytes and over-long text on both positions
    line_q.delete(); add_text("$GNRMC,,1,,A,,");
    line_q.push_back(8'h01); line_q.push_back(8'hFF); line_q.push_back(8'h00);
    line_q.push_back(8'h80); line_q.push_back(8'h7F);
    add_text("0123456789ABCDEF,N,12345678901234567"); add_star_sum(8'h00, 1'b0);
    send_line();
    // stars inside tokens, longitude token missing
    line_q.delete(); add_text("$GNRMC,1*2,A,4*8"); add_star_sum(8'h00, 1'b0); send_line();
    // three hex digits: overflow, then a harmless leading zero
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); s = line_sum();
    add_text("*1"); add_hex(s, 1'b0); send_line();
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); s = line_sum();
    add_text("*0"); add_hex(s, 1'b0); send_line();
    // no digits, a 0x prefix, a void after the checksum
    line_q.delete(); add_text("$GNRMC*"); send_line();
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); s = line_sum();
    add_text("*0x"); add_hex(s, 1'b0); send_line();
    line_q.delete(); add_text("$GNRMC,1,A,48,N,11,E"); add_star_sum(8'h00, 1'b0);
    add_text("V"); send_line();
    // one-byte sentences
    line_q.delete(); add_text("$"); send_line();
    line_q.delete(); add_text("*"); send_line();
    drain_results();

    base = bytes_sent;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 55 : 0;
      rx_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 34 : 0;
      do begin
        gen_random_line();
        send_line();
      end while (bytes_sent - base < (ph + 1) * RANDOM_BYTES / 3);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
